[rtl/core/assert_macros.svh]
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while reset is low.
`define SBFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same check, also evaluated while reset is low.
`define SBFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/core/sbfd_pkg.sv]
// ----------------------------------------------------------------------------
// sbfd_pkg
// Types and constants shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int unsigned ChannelCountDefault = 12;
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ChanBits = 11;
  localparam int unsigned MaxDataBits = MaxChannels * ChanBits;

  localparam logic [7:0] StartByte = 8'h0F;
  localparam logic [7:0] EndByte = 8'h00;
  localparam logic [4:0] FlagsPos = 5'd23;
  localparam logic [4:0] EndPos = 5'd24;

  localparam logic [7:0] GapReset = 8'd60;
  localparam logic [15:0] LossTicksReset = 16'd20000;
  localparam logic [15:0] LossCountReset = 16'd1000;

  localparam logic [7:0] RssiMax = 8'd240;
  localparam logic [7:0] RssiMin = 8'd50;
  localparam logic [7:0] RssiStep = 8'd10;

  localparam logic [15:0] PulseGain = 16'd40942;
  localparam logic [27:0] PulseOffset = 28'd57708838;

  // register indexes
  localparam logic [1:0] CfgGap = 2'd0;
  localparam logic [1:0] CfgLoss = 2'd1;
  localparam logic [1:0] CfgCut = 2'd2;

  // indicator codes
  localparam logic [2:0] IndOkHold = 3'd0;
  localparam logic [2:0] IndOkCut = 3'd1;
  localparam logic [2:0] IndFsHold = 3'd2;
  localparam logic [2:0] IndFsCut = 3'd3;
  localparam logic [2:0] IndNoSignal = 3'd4;

  typedef struct packed {
    logic [7:0]  gap_ticks;
    logic [15:0] loss_ticks;
    logic        cut;
  } cfg_t;

  typedef struct packed {
    logic                   status_only;
    logic                   failsafe;
    logic                   frame_lost;
    logic                   link_ready;
    logic                   output_enable;
    logic [7:0]             rssi;
    logic [2:0]             indicator;
    logic [MaxDataBits-1:0] data;
  } event_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [11:0] pulse_us;
    logic        last;
    logic        status_only;
    logic        failsafe;
    logic        frame_lost;
    logic        link_ready;
    logic        output_enable;
    logic [7:0]  rssi_level;
    logic [2:0]  indicator;
  } result_t;

endpackage

[rtl/core/sbfd_front.sv]
// ----------------------------------------------------------------------------
// sbfd_front
// Byte and tick intake: frame gathering, resync, link and RSSI state.
// ----------------------------------------------------------------------------
module sbfd_front #(
  parameter int unsigned CHANNEL_COUNT = sbfd_pkg::ChannelCountDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbfd_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output sbfd_pkg::event_t ev_o
);

  localparam int unsigned NBytes = (CHANNEL_COUNT * sbfd_pkg::ChanBits + 7) / 8;

  logic [4:0]          pos_q, pos_d;
  logic                disc_q, disc_d;
  logic [7:0]          gap_q, gap_d;
  logic [15:0]         loss_q, loss_d;
  logic [NBytes*8-1:0] data_q, data_d;
  logic [7:0]          flags_q, flags_d;
  logic                ready_q, ready_d;
  logic                enable_q, enable_d;
  logic [7:0]          rssi_q, rssi_d;
  logic [2:0]          ind_q, ind_d;

  assign in_ready_o = !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      disc_q   <= 1'b0;
      gap_q    <= sbfd_pkg::GapReset;
      loss_q   <= sbfd_pkg::LossCountReset;
      ready_q  <= 1'b0;
      enable_q <= 1'b0;
      rssi_q   <= '0;
      ind_q    <= sbfd_pkg::IndNoSignal;
    end else begin
      pos_q    <= pos_d;
      disc_q   <= disc_d;
      gap_q    <= gap_d;
      loss_q   <= loss_d;
      ready_q  <= ready_d;
      enable_q <= enable_d;
      rssi_q   <= rssi_d;
      ind_q    <= ind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    flags_q <= flags_d;
  end

  always_comb begin
    logic [7:0]  gap_t;
    logic [15:0] loss_t;
    logic        rd, en, fs, lost;
    logic [7:0]  r;
    logic [2:0]  ind;
    pos_d    = pos_q;
    disc_d   = disc_q;
    gap_d    = gap_q;
    loss_d   = loss_q;
    data_d   = data_q;
    flags_d  = flags_q;
    ready_d  = ready_q;
    enable_d = enable_q;
    rssi_d   = rssi_q;
    ind_d    = ind_q;
    push_o   = 1'b0;
    ev_o     = '0;
    gap_t    = '0;
    loss_t   = '0;
    fs       = flags_q[3];
    lost     = flags_q[2];
    rd       = ready_q;
    en       = enable_q;
    r        = rssi_q;
    ind      = ind_q;
    if (in_valid_i && in_ready_o) begin
      if (command_i) begin
        gap_t  = (gap_q != '0) ? gap_q - 8'd1 : gap_q;
        loss_t = (loss_q != '0) ? loss_q - 16'd1 : loss_q;
        loss_d = loss_t;
        if (gap_t == '0) begin
          pos_d  = '0;
          disc_d = 1'b0;
          gap_d  = cfg_i.gap_ticks;
        end else begin
          gap_d = gap_t;
        end
        if (loss_t == '0 && ready_q) begin
          ready_d            = 1'b0;
          enable_d           = 1'b0;
          ind_d              = sbfd_pkg::IndNoSignal;
          push_o             = 1'b1;
          ev_o.status_only   = 1'b1;
          ev_o.rssi          = rssi_q;
          ev_o.indicator     = sbfd_pkg::IndNoSignal;
        end
      end else begin
        gap_d = cfg_i.gap_ticks;
        if (!disc_q) begin
          if ((pos_q == '0 && rx_byte_i != sbfd_pkg::StartByte) ||
              (pos_q == sbfd_pkg::EndPos && rx_byte_i != sbfd_pkg::EndByte)) begin
            disc_d = 1'b1;
          end else begin
            for (int i = 0; i < NBytes; i++) begin
              if (pos_q == 5'(i + 1)) data_d[i*8 +: 8] = rx_byte_i;
            end
            if (pos_q == sbfd_pkg::FlagsPos) flags_d = rx_byte_i;
            if (pos_q == sbfd_pkg::EndPos) begin
              pos_d = '0;
              if (!fs) begin
                if (!rd) begin
                  rd  = 1'b1;
                  en  = 1'b1;
                  ind = cfg_i.cut ? sbfd_pkg::IndOkCut : sbfd_pkg::IndOkHold;
                end
              end else begin
                r = '0;
                if (rd) begin
                  rd  = 1'b0;
                  ind = cfg_i.cut ? sbfd_pkg::IndFsCut : sbfd_pkg::IndFsHold;
                  if (cfg_i.cut) en = 1'b0;
                end
              end
              if (!lost) begin
                if (r < sbfd_pkg::RssiMax) r = r + sbfd_pkg::RssiStep;
              end else if (r > sbfd_pkg::RssiMin) begin
                r = r - sbfd_pkg::RssiStep;
              end
              ready_d            = rd;
              enable_d           = en;
              rssi_d             = r;
              ind_d              = ind;
              loss_d             = cfg_i.loss_ticks;
              push_o             = 1'b1;
              ev_o.failsafe      = fs;
              ev_o.frame_lost    = lost;
              ev_o.link_ready    = rd;
              ev_o.output_enable = en;
              ev_o.rssi          = r;
              ev_o.indicator     = ind;
              ev_o.data          = sbfd_pkg::MaxDataBits'(data_q);
            end else begin
              pos_d = pos_q + 5'd1;
            end
          end
        end
      end
    end
  end

endmodule

[rtl/core/sbfd_queue.sv]
// ----------------------------------------------------------------------------
// sbfd_queue
// Two-entry event queue between intake and result generation.
// ----------------------------------------------------------------------------
module sbfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbfd_pkg::event_t push_data_i,
  input  logic             pop_i,
  output sbfd_pkg::event_t pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  sbfd_pkg::event_t mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

[rtl/core/sbfd_back.sv]
// ----------------------------------------------------------------------------
// sbfd_back
// Per-channel unpack, glitch filter, pulse mapping and result register.
// ----------------------------------------------------------------------------
module sbfd_back #(
  parameter int unsigned CHANNEL_COUNT = sbfd_pkg::ChannelCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  sbfd_pkg::event_t  q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbfd_pkg::result_t res_o
);

  localparam int unsigned IdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [3:0] LastChan = 4'(CHANNEL_COUNT - 1);

  sbfd_pkg::event_t  ev_q, ev_d;
  logic              busy_q, busy_d;
  logic [3:0]        chan_q, chan_d;
  logic [10:0]       prev_q [CHANNEL_COUNT];
  logic [10:0]       older_q [CHANNEL_COUNT];
  logic              vld_q, vld_d;
  sbfd_pkg::result_t res_q, res_d;

  logic              emit;
  logic [IdxW-1:0]   idx;
  logic [10:0]       raw, pv, ov, pnew, val;
  logic [27:0]       prod;

  assign idx  = chan_q[IdxW-1:0];
  assign raw  = ev_q.data[10:0];
  assign pv   = prev_q[idx];
  assign ov   = older_q[idx];
  assign emit = busy_q && (!vld_q || out_ready_i);
  assign pop_o = !busy_q && !q_empty_i;

  always_comb begin
    pnew = pv;
    val  = raw;
    if (ov == pv && pv != raw) begin
      pnew = raw;
      if (ov != '0) val = ov;
    end
  end

  assign prod = 28'(val) * 28'(sbfd_pkg::PulseGain) + sbfd_pkg::PulseOffset;

  always_comb begin
    ev_d   = ev_q;
    busy_d = busy_q;
    chan_d = chan_q;
    vld_d  = (vld_q && !out_ready_i);
    res_d  = res_q;
    if (pop_o) begin
      ev_d   = q_data_i;
      busy_d = 1'b1;
      chan_d = '0;
    end else if (emit) begin
      vld_d               = 1'b1;
      res_d.status_only   = ev_q.status_only;
      res_d.failsafe      = ev_q.failsafe;
      res_d.frame_lost    = ev_q.frame_lost;
      res_d.link_ready    = ev_q.link_ready;
      res_d.output_enable = ev_q.output_enable;
      res_d.rssi_level    = ev_q.rssi;
      res_d.indicator     = ev_q.indicator;
      if (ev_q.status_only) begin
        res_d.channel_index = '0;
        res_d.channel_value = '0;
        res_d.pulse_us      = '0;
        res_d.last          = 1'b1;
        busy_d              = 1'b0;
      end else begin
        res_d.channel_index = chan_q;
        res_d.channel_value = val;
        res_d.pulse_us      = prod[27:16];
        res_d.last          = (chan_q == LastChan);
        ev_d.data           = ev_q.data >> sbfd_pkg::ChanBits;
        chan_d              = chan_q + 4'd1;
        if (chan_q == LastChan) busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chan_q <= '0;
      vld_q  <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        prev_q[i]  <= '0;
        older_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      chan_q <= chan_d;
      vld_q  <= vld_d;
      if (emit && !pop_o && !ev_q.status_only) begin
        prev_q[idx]  <= val;
        older_q[idx] <= pnew;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q  <= ev_d;
    res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

[rtl/core/sbus_frame_decoder.sv]
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial frame decoder: gathers 25-byte frames, emits filtered channels.
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   command_i, rx_byte_i
//   out       out_valid_o / out_ready_i channel_index_o .. indicator_o
//   cfg       cfg_we_i                  cfg_index_i, cfg_data_i
//
// An input item is accepted whenever in_ready_o is high; the intake stalls only when the
// two-entry event queue is full. A completed frame gives CHANNEL_COUNT results,
// one per cycle from the result stage while the output is not stalled (one filter
// and one multiply per channel).
// Reset is asynchronous and clears all control state and the filter history.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbus_frame_decoder #(
  parameter int unsigned CHANNEL_COUNT = sbfd_pkg::ChannelCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic [11:0] pulse_us_o,
  output logic        last_o,
  output logic        status_only_o,
  output logic        failsafe_o,
  output logic        frame_lost_o,
  output logic        link_ready_o,
  output logic        output_enable_o,
  output logic [7:0]  rssi_level_o,
  output logic [2:0]  indicator_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  sbfd_pkg::cfg_t    cfg_q, cfg_d;
  sbfd_pkg::event_t  push_data, pop_data;
  sbfd_pkg::result_t res;
  logic              push, pop, q_full, q_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbfd_pkg::CfgGap:  cfg_d.gap_ticks  = cfg_data_i[7:0];
        sbfd_pkg::CfgLoss: cfg_d.loss_ticks = cfg_data_i;
        sbfd_pkg::CfgCut:  cfg_d.cut        = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_ticks  <= sbfd_pkg::GapReset;
      cfg_q.loss_ticks <= sbfd_pkg::LossTicksReset;
      cfg_q.cut        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbfd_front #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .ev_o       (push_data)
  );

  sbfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  sbfd_back #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign channel_index_o = res.channel_index;
  assign channel_value_o = res.channel_value;
  assign pulse_us_o      = res.pulse_us;
  assign last_o          = res.last;
  assign status_only_o   = res.status_only;
  assign failsafe_o      = res.failsafe;
  assign frame_lost_o    = res.frame_lost;
  assign link_ready_o    = res.link_ready;
  assign output_enable_o = res.output_enable;
  assign rssi_level_o    = res.rssi_level;
  assign indicator_o     = res.indicator;

  `SBFD_ASSERT(a_status_last, clk_i, rst_ni, out_valid_o && status_only_o |-> last_o)
  `SBFD_ASSERT(a_status_nosig, clk_i, rst_ni, out_valid_o && status_only_o |-> indicator_o == sbfd_pkg::IndNoSignal && !link_ready_o && !output_enable_o)
  `SBFD_ASSERT(a_chan_range, clk_i, rst_ni, out_valid_o && !status_only_o |-> channel_index_o <= 4'(CHANNEL_COUNT - 1) && (last_o == (channel_index_o == 4'(CHANNEL_COUNT - 1))))

endmodule
